@@ rtl/swarq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package swarq_pkg;

	// field widths
	localparam int TickBits   = 24;
	localparam int FragBits   = 16;
	localparam int TmoBits    = 29;
	localparam int RetryBits  = 9;
	localparam int LimitBits  = 8;
	localparam int CfgBits    = 29;
	localparam int CfgIdxBits = 2;

	localparam logic [TickBits-1:0]  TickMax    = {TickBits{1'b1}};
	localparam logic [TmoBits-1:0]   TimeoutMax = 29'd402653160;
	localparam logic [RetryBits-1:0] RetryMax   = {RetryBits{1'b1}};

	// register reset values
	localparam logic [FragBits-1:0]  TotalFragReset = 16'd1;
	localparam logic [TickBits-1:0]  InitRttReset   = '0;
	localparam logic [LimitBits-1:0] RetryLimReset  = 8'd32;
	localparam logic [TmoBits-1:0]   FirstTmoReset  = 29'd999999;

	// configuration register indexes
	typedef enum logic [CfgIdxBits-1:0] {
		CFG_TOTAL_FRAGMENTS = 2'd0,
		CFG_INITIAL_RTT     = 2'd1,
		CFG_RETRY_LIMIT     = 2'd2,
		CFG_FIRST_TIMEOUT   = 2'd3
	} cfg_idx_t;

	// request codes
	typedef enum logic [1:0] {
		REQ_START   = 2'd0,
		REQ_ACK     = 2'd1,
		REQ_TIMEOUT = 2'd2,
		REQ_UNUSED  = 2'd3
	} req_t;

	// result action codes
	typedef enum logic [1:0] {
		ACT_WAIT  = 2'd0,
		ACT_SEND  = 2'd1,
		ACT_FIN   = 2'd2,
		ACT_ABORT = 2'd3
	} act_t;

	// transfer phase, one-hot
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_WAIT = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	// round-trip estimator pair
	typedef struct packed {
		logic [TickBits-1:0] est;
		logic [TickBits-1:0] dev;
	} rtt_state_t;

endpackage

`default_nettype wire

@@ rtl/stop_wait_arq_sender_rtt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Stop-and-wait ARQ sender with an adaptive retransmit timeout.
// The request channel (in_valid / in_stall) takes one event: start, ack
// arrived or wait timed out, with the ack's fragment number and the ticks
// elapsed since the fragment went out. Every request gives exactly one
// result on the result channel (out_valid / out_stall): keep waiting, send
// a fragment, send fin or abort, with the fragment, the timeout to arm and
// the retry count.
// A request is registered on accept, and its result is registered in the
// result register once that register is free. The block takes one request
// per cycle unless the receiver stalls; the estimator update is one pass of
// constant multiplies and adds between the request and result registers.
// Reset loads the configuration defaults and leaves the transfer idle.
// While the receiver stalls, the result register holds; one more request
// is taken into the request register, then in_stall rises until the result
// is taken. Configuration is written through cfg_we / cfg_index / cfg_data;
// the user must do so only while the block is idle; it is not enforced.
module stop_wait_arq_sender_rtt
	import swarq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CfgIdxBits-1:0]  cfg_index,
	input  logic [CfgBits-1:0]     cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             req_type,
	input  logic [FragBits-1:0]    ack_fragment,
	input  logic [TickBits-1:0]    elapsed_ticks,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             action,
	output logic [FragBits-1:0]    send_fragment,
	output logic [TmoBits-1:0]     timeout_ticks,
	output logic [RetryBits-1:0]   retries
);

	// configuration registers
	logic [FragBits-1:0]  total_frag_q;
	logic [TickBits-1:0]  init_rtt_q;
	logic [LimitBits-1:0] retry_lim_q;
	logic [TmoBits-1:0]   first_tmo_q;

	// transfer state
	phase_t               phase_q, phase_d;
	logic [FragBits-1:0]  frag_q, frag_d;
	logic [RetryBits-1:0] retry_q, retry_d;
	rtt_state_t           rtt_q, rtt_d;
	logic [TmoBits-1:0]   tmo_q, tmo_d;

	// request stage
	logic                 valid_s1;
	req_t                 req_s1;
	logic [FragBits-1:0]  ack_s1;
	logic [TickBits-1:0]  ticks_s1;

	// result register
	logic                 out_valid_q;
	act_t                 act_q, act_d;
	logic [FragBits-1:0]  ofrag_q, ofrag_d;
	logic [TmoBits-1:0]   otmo_q, otmo_d;
	logic [RetryBits-1:0] oretry_q, oretry_d;

	logic                 advance;
	rtt_state_t           rtt_upd;
	logic [TmoBits-1:0]   tmo_upd;
	logic [TickBits:0]    seed_x2;
	logic [RetryBits-1:0] retry_inc;

	// handshake
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_frag_q <= TotalFragReset;
			init_rtt_q   <= InitRttReset;
			retry_lim_q  <= RetryLimReset;
			first_tmo_q  <= FirstTmoReset;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TOTAL_FRAGMENTS: total_frag_q <= cfg_data[FragBits-1:0];
				CFG_INITIAL_RTT:     init_rtt_q   <= cfg_data[TickBits-1:0];
				CFG_RETRY_LIMIT:     retry_lim_q  <= cfg_data[LimitBits-1:0];
				CFG_FIRST_TIMEOUT:   first_tmo_q  <= cfg_data[TmoBits-1:0];
			endcase
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1   <= req_t'(req_type);
			ack_s1   <= ack_fragment;
			ticks_s1 <= elapsed_ticks;
		end
	end

	// estimator update
	swarq_rtt u_rtt (
		.cur     (rtt_q),
		.sample  (ticks_s1),
		.nxt     (rtt_upd),
		.timeout (tmo_upd)
	);

	assign seed_x2   = {init_rtt_q, 1'b0};
	assign retry_inc = (retry_q < RetryMax) ? retry_q + RetryBits'(1) : retry_q;

	// next state and result for the request in stage one
	always_comb begin
		phase_d  = phase_q;
		frag_d   = frag_q;
		retry_d  = retry_q;
		rtt_d    = rtt_q;
		tmo_d    = tmo_q;
		act_d    = ACT_WAIT;
		ofrag_d  = frag_q;
		otmo_d   = tmo_q;
		oretry_d = retry_q;
		priority if (req_s1 == REQ_START) begin
			retry_d   = '0;
			rtt_d.est = seed_x2[TickBits] ? TickMax : seed_x2[TickBits-1:0];
			rtt_d.dev = init_rtt_q;
			tmo_d     = first_tmo_q;
			otmo_d    = first_tmo_q;
			oretry_d  = '0;
			if (total_frag_q == '0) begin
				frag_d  = '0;
				phase_d = PH_DONE;
				act_d   = ACT_FIN;
				ofrag_d = '0;
			end else begin
				frag_d  = FragBits'(1);
				phase_d = PH_WAIT;
				act_d   = ACT_SEND;
				ofrag_d = FragBits'(1);
			end
		end else if (phase_q == PH_WAIT && req_s1 == REQ_ACK && ack_s1 == frag_q) begin
			rtt_d    = rtt_upd;
			tmo_d    = tmo_upd;
			otmo_d   = tmo_upd;
			retry_d  = '0;
			oretry_d = '0;
			if (frag_q >= total_frag_q) begin
				frag_d  = '0;
				phase_d = PH_DONE;
				act_d   = ACT_FIN;
				ofrag_d = '0;
			end else begin
				frag_d  = frag_q + FragBits'(1);
				act_d   = ACT_SEND;
				ofrag_d = frag_q + FragBits'(1);
			end
		end else if (phase_q == PH_WAIT && req_s1 == REQ_TIMEOUT) begin
			retry_d  = retry_inc;
			oretry_d = retry_inc;
			if (retry_inc > RetryBits'(retry_lim_q)) begin
				// give up: estimators stay as they are
				phase_d = PH_DONE;
				act_d   = ACT_ABORT;
			end else begin
				rtt_d  = rtt_upd;
				tmo_d  = tmo_upd;
				otmo_d = tmo_upd;
				act_d  = ACT_SEND;
			end
		end else begin
			// keep waiting: state and result take the defaults above
		end
	end

	// transfer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			frag_q  <= '0;
			retry_q <= '0;
			rtt_q   <= '0;
			tmo_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			frag_q  <= frag_d;
			retry_q <= retry_d;
			rtt_q   <= rtt_d;
			tmo_q   <= tmo_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			act_q    <= act_d;
			ofrag_q  <= ofrag_d;
			otmo_q   <= otmo_d;
			oretry_q <= oretry_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = act_q;
	assign send_fragment = ofrag_q;
	assign timeout_ticks = otmo_q;
	assign retries       = oretry_q;

endmodule

`default_nettype wire

@@ rtl/swarq_rtt.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swarq_rtt
	import swarq_pkg::*;
(
	input  rtt_state_t          cur,
	input  logic [TickBits-1:0] sample,
	output rtt_state_t          nxt,
	output logic [TmoBits-1:0]  timeout
);

	logic [TickBits+2:0] est_x7;
	logic [TickBits:0]   est_sum;
	logic [TickBits-1:0] est_new;
	logic [TickBits-1:0] diff;
	logic [TickBits+1:0] dev_x3;
	logic [TickBits:0]   dev_sum;
	logic [TickBits-1:0] dev_new;
	logic [TmoBits:0]    tmo_sum;

	// est = 7/8 est + s/8, saturated
	always_comb begin
		est_x7  = {3'b000, cur.est} * (TickBits+3)'(7);
		est_sum = {1'b0, est_x7[TickBits+2:3]} + {4'b0000, sample[TickBits-1:3]};
		est_new = est_sum[TickBits] ? TickMax : est_sum[TickBits-1:0];
	end

	// dev = 3/4 dev + |est - s|/4, against the new est
	always_comb begin
		diff    = (est_new > sample) ? (est_new - sample) : (sample - est_new);
		dev_x3  = {2'b00, cur.dev} * (TickBits+2)'(3);
		dev_sum = {1'b0, dev_x3[TickBits+1:2]} + {3'b000, diff[TickBits-1:2]};
		dev_new = dev_sum[TickBits] ? TickMax : dev_sum[TickBits-1:0];
	end

	// timeout = 20 est + 4 dev, saturated
	always_comb begin
		tmo_sum = (TmoBits+1)'({est_new, 4'b0000})
			+ (TmoBits+1)'({est_new, 2'b00})
			+ (TmoBits+1)'({dev_new, 2'b00});
		timeout = (tmo_sum > (TmoBits+1)'(TimeoutMax)) ? TimeoutMax
			: tmo_sum[TmoBits-1:0];
	end

	assign nxt.est = est_new;
	assign nxt.dev = dev_new;

endmodule

`default_nettype wire

@@ test/stop_wait_arq_sender_rtt_tb.sv @@
`timescale 1ns / 1ps

module stop_wait_arq_sender_rtt_tb;
	import swarq_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int PhaseReqs  = 190;
	localparam int RandPhases = 10;

	typedef struct {
		req_t                kind;
		logic [FragBits-1:0] ack;
		logic [TickBits-1:0] ticks;
	} arq_req_t;

	typedef struct {
		act_t                 act;
		logic [FragBits-1:0]  frag;
		logic [TmoBits-1:0]   tmo;
		logic [RetryBits-1:0] tries;
	} arq_result_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CfgIdxBits-1:0] cfg_index     = '0;
	logic [CfgBits-1:0]    cfg_data      = '0;
	logic                  in_valid      = 1'b0;
	logic                  in_stall;
	logic [1:0]            req_type      = '0;
	logic [FragBits-1:0]   ack_fragment  = '0;
	logic [TickBits-1:0]   elapsed_ticks = '0;
	logic                  out_valid;
	logic                  out_stall     = 1'b0;
	logic [1:0]            action;
	logic [FragBits-1:0]   send_fragment;
	logic [TmoBits-1:0]    timeout_ticks;
	logic [RetryBits-1:0]  retries;

	stop_wait_arq_sender_rtt dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.ack_fragment (ack_fragment),
		.elapsed_ticks(elapsed_ticks),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action),
		.send_fragment(send_fragment),
		.timeout_ticks(timeout_ticks),
		.retries      (retries)
	);

	// request and result stores
	arq_req_t    pending_reqs[$];
	arq_result_t expected_results[$];
	arq_req_t    held_req;
	arq_result_t want;

	// shadow of the configuration registers
	logic [FragBits-1:0]  cfg_total = TotalFragReset;
	logic [TickBits-1:0]  cfg_rtt   = InitRttReset;
	logic [LimitBits-1:0] cfg_limit = RetryLimReset;
	logic [TmoBits-1:0]   cfg_first = FirstTmoReset;

	// sender state as predicted
	logic [FragBits-1:0]  st_frag  = '0;
	logic [RetryBits-1:0] st_tries = '0;
	logic [TickBits-1:0]  st_est   = '0;
	logic [TickBits-1:0]  st_dev   = '0;
	phase_t               st_phase = PH_IDLE;
	logic [TmoBits-1:0]   st_tmo   = '0;

	bit quiet = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int reqs_queued = 0;
	int reqs_taken = 0;
	int results_seen = 0;
	int mismatches = 0;
	int cfg_sets = 0;
	int cycle_count = 0;
	int act_tally[4] = '{0, 0, 0, 0};

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 100) begin
			$display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
		end
		mismatches++;
	endtask

	function automatic logic [TickBits-1:0] clamp_tick(input logic [63:0] v);
		return (v > 64'(TickMax)) ? TickMax : v[TickBits-1:0];
	endfunction

	// fold one round-trip sample into the estimators and rearm the timeout
	function automatic void fold_sample(input logic [TickBits-1:0] ticks);
		logic [63:0] s, est, diff, dev, t;
		s = 64'(ticks);
		est = 64'(clamp_tick(((64'd7 * 64'(st_est)) >> 3) + (s >> 3)));
		diff = (est > s) ? est - s : s - est;
		dev = 64'(clamp_tick(((64'd3 * 64'(st_dev)) >> 2) + (diff >> 2)));
		t = 64'd20 * est + 64'd4 * dev;
		st_est = est[TickBits-1:0];
		st_dev = dev[TickBits-1:0];
		st_tmo = (t > 64'(TimeoutMax)) ? TimeoutMax : t[TmoBits-1:0];
	endfunction

	// next sender decision for one request
	function automatic arq_result_t predict_sender(input arq_req_t rq);
		arq_result_t r;
		r.act = ACT_WAIT;
		if (rq.kind == REQ_START) begin
			st_tries = '0;
			st_est = clamp_tick({40'd0, cfg_rtt} << 1);
			st_dev = cfg_rtt;
			st_tmo = cfg_first;
			if (cfg_total == '0) begin
				st_frag = '0;
				st_phase = PH_DONE;
				r.act = ACT_FIN;
			end else begin
				st_frag = FragBits'(1);
				st_phase = PH_WAIT;
				r.act = ACT_SEND;
			end
		end else if (st_phase == PH_WAIT && rq.kind == REQ_ACK && rq.ack == st_frag) begin
			fold_sample(rq.ticks);
			st_tries = '0;
			if (st_frag >= cfg_total) begin
				st_frag = '0;
				st_phase = PH_DONE;
				r.act = ACT_FIN;
			end else begin
				st_frag = st_frag + FragBits'(1);
				r.act = ACT_SEND;
			end
		end else if (st_phase == PH_WAIT && rq.kind == REQ_TIMEOUT) begin
			if (st_tries != RetryMax) st_tries = st_tries + RetryBits'(1);
			if (st_tries > RetryBits'(cfg_limit)) begin
				// retries used up: abort without touching the estimators
				st_phase = PH_DONE;
				r.act = ACT_ABORT;
			end else begin
				fold_sample(rq.ticks);
				r.act = ACT_SEND;
			end
		end
		r.frag = st_frag;
		r.tmo = st_tmo;
		r.tries = st_tries;
		return r;
	endfunction

	// request driver with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_sender(held_req));
				reqs_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					held_req = pending_reqs.pop_front();
					req_type <= held_req.kind;
					ack_fragment <= held_req.ack;
					elapsed_ticks <= held_req.ticks;
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 9) == 0)
						send_gap = int'($urandom_range(1, 18));
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing pending");
				end else begin
					want = expected_results.pop_front();
					if (action !== want.act)
						report_mismatch($sformatf("action %0d, want %s", action, want.act.name()));
					if (send_fragment !== want.frag)
						report_mismatch($sformatf("send_fragment %0d, want %0d",
							send_fragment, want.frag));
					if (timeout_ticks !== want.tmo)
						report_mismatch($sformatf("timeout_ticks %0d, want %0d",
							timeout_ticks, want.tmo));
					if (retries !== want.tries)
						report_mismatch($sformatf("retries %0d, want %0d", retries, want.tries));
					act_tally[want.act]++;
				end
				results_seen++;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = int'($urandom_range(0, 17));
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic add_req(input req_t k, input logic [FragBits-1:0] frag,
			input logic [TickBits-1:0] ticks);
		arq_req_t rq;
		rq.kind = k;
		rq.ack = frag;
		rq.ticks = ticks;
		pending_reqs.push_back(rq);
		reqs_queued++;
	endtask

	function automatic logic [TickBits-1:0] rand_ticks();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return TickMax;
			2, 3: return TickBits'($urandom_range(0, 32'hFFFFFF));
			default: return TickBits'($urandom_range(0, 20000));
		endcase
	endfunction

	// wait until every request is taken and every result is back
	task automatic settle();
		@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_idx_t idx, input logic [CfgBits-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_TOTAL_FRAGMENTS: cfg_total = val[FragBits-1:0];
			CFG_INITIAL_RTT:     cfg_rtt = val[TickBits-1:0];
			CFG_RETRY_LIMIT:     cfg_limit = val[LimitBits-1:0];
			CFG_FIRST_TIMEOUT:   cfg_first = val[TmoBits-1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_config(input logic [FragBits-1:0] tot, input logic [TickBits-1:0] rtt,
			input logic [LimitBits-1:0] lim, input logic [TmoBits-1:0] first);
		write_cfg(CFG_TOTAL_FRAGMENTS, CfgBits'(tot));
		write_cfg(CFG_INITIAL_RTT, CfgBits'(rtt));
		write_cfg(CFG_RETRY_LIMIT, CfgBits'(lim));
		write_cfg(CFG_FIRST_TIMEOUT, CfgBits'(first));
		cfg_sets++;
		@(negedge clk);
	endtask

	task automatic random_config();
		logic [FragBits-1:0]  tot;
		logic [TickBits-1:0]  rtt;
		logic [LimitBits-1:0] lim;
		logic [TmoBits-1:0]   first;
		case ($urandom_range(0, 9))
			0: tot = 16'd1;
			1: tot = 16'hFFFF;
			2: tot = '0;
			3, 4: tot = FragBits'($urandom_range(2, 40));
			default: tot = FragBits'($urandom_range(1, 8));
		endcase
		case ($urandom_range(0, 3))
			0: rtt = '0;
			1: rtt = TickMax;
			2: rtt = TickBits'($urandom_range(0, 32'hFFFFFF));
			default: rtt = TickBits'($urandom_range(0, 2000));
		endcase
		case ($urandom_range(0, 4))
			0: lim = '0;
			1: lim = 8'hFF;
			2: lim = LimitBits'($urandom_range(0, 255));
			default: lim = LimitBits'($urandom_range(0, 4));
		endcase
		case ($urandom_range(0, 3))
			0: first = '0;
			1: first = TimeoutMax;
			default: first = TmoBits'($urandom_range(0, 32'(TimeoutMax)));
		endcase
		apply_config(tot, rtt, lim, first);
	endtask

	// stray acks with a wrong fragment or unused codes
	task automatic maybe_noise(input logic [FragBits-1:0] frag);
		if ($urandom_range(0, 9) == 0) begin
			if ($urandom_range(0, 1) == 0)
				add_req(REQ_ACK, frag ^ 16'($urandom_range(1, 65535)), rand_ticks());
			else
				add_req(REQ_UNUSED, FragBits'($urandom), rand_ticks());
		end
	endtask

	function automatic int pick_timeouts();
		int lim1;
		lim1 = int'(cfg_limit) + 1;
		case ($urandom_range(0, 15))
			14: return int'($urandom_range(0, (lim1 > 40) ? 40 : lim1));
			15: return (lim1 > 41) ? 3 : lim1;
			10, 11, 12, 13: return int'($urandom_range(1, 2));
			default: return 0;
		endcase
	endfunction

	// one transfer: start, then per fragment some timeouts and a matching ack
	task automatic gen_transfer();
		logic [FragBits-1:0] frag;
		int n_to, tries, span;
		frag = FragBits'(1);
		add_req(REQ_START, FragBits'($urandom), rand_ticks());
		if (cfg_total == '0) return;
		span = int'($urandom_range(1, 12));
		for (int f = 0; f < span; f++) begin
			tries = 0;
			n_to = pick_timeouts();
			for (int k = 0; k < n_to; k++) begin
				maybe_noise(frag);
				add_req(REQ_TIMEOUT, FragBits'($urandom), rand_ticks());
				tries++;
				if (tries > int'(cfg_limit)) return;
			end
			maybe_noise(frag);
			add_req(REQ_ACK, frag, rand_ticks());
			if (frag >= cfg_total) return;
			frag = frag + FragBits'(1);
		end
	endtask

	// stimulus
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration: requests while idle, mismatch, timeout, fin, restart
		cfg_sets++;
		add_req(REQ_ACK, '0, '0);
		add_req(REQ_TIMEOUT, '0, TickMax);
		add_req(REQ_UNUSED, 16'hFFFF, TickMax);
		add_req(REQ_START, '0, '0);
		add_req(REQ_ACK, 16'd2, 24'd100);
		add_req(REQ_TIMEOUT, 16'hFFFF, TickMax);
		add_req(REQ_ACK, 16'd1, '0);
		add_req(REQ_ACK, '0, 24'd5);
		add_req(REQ_START, 16'hFFFF, TickMax);
		add_req(REQ_START, '0, '0);

		// zero fragments: fin at once; seed saturates; largest first timeout
		settle();
		apply_config('0, TickMax, '0, TimeoutMax);
		add_req(REQ_START, '0, '0);
		add_req(REQ_TIMEOUT, '0, 24'd7);

		// abort on the first timeout with no retries allowed
		settle();
		apply_config(16'd10, TickMax, '0, TimeoutMax);
		add_req(REQ_START, '0, '0);
		add_req(REQ_ACK, 16'd1, '0);
		add_req(REQ_ACK, 16'd2, TickMax);
		add_req(REQ_TIMEOUT, '0, 24'd300);
		add_req(REQ_ACK, 16'd3, 24'd300);
		add_req(REQ_START, '0, '0);
		add_req(REQ_ACK, 16'd1, 24'd1);
		add_req(REQ_ACK, 16'd2, 24'h800000);
		add_req(REQ_ACK, 16'd3, '0);
		add_req(REQ_ACK, 16'd4, TickMax);

		// fragment count lowered under the fragment in flight: ack gives fin
		settle();
		write_cfg(CFG_TOTAL_FRAGMENTS, CfgBits'(3));
		@(negedge clk);
		add_req(REQ_ACK, 16'd5, 24'd40);

		// random transfers under several configurations
		for (int p = 0; p < RandPhases; p++) begin
			settle();
			if (p == 1) apply_config(16'hFFFF, '0, 8'hFF, '0);
			else if (p == 2) apply_config(16'd1, TickMax, '0, TimeoutMax);
			else random_config();
			if (p == RandPhases - 1) quiet = 1'b1;
			reqs_queued = 0;
			if (p == 1) begin
				// run the retry count past its limit of 255 to an abort
				add_req(REQ_START, '0, rand_ticks());
				repeat (256) add_req(REQ_TIMEOUT, FragBits'($urandom), rand_ticks());
			end
			while (reqs_queued < PhaseReqs) begin
				gen_transfer();
				if ($urandom_range(0, 4) == 0)
					add_req(($urandom_range(0, 1) == 0) ? REQ_TIMEOUT : REQ_ACK,
						FragBits'($urandom), rand_ticks());
			end
		end

		settle();
		$display("run covered %0d requests under %0d register settings", reqs_taken, cfg_sets);
		$display("results: %0d send, %0d fin, %0d abort, %0d keep waiting, %0d mismatches",
			act_tally[ACT_SEND], act_tally[ACT_FIN], act_tally[ACT_ABORT],
			act_tally[ACT_WAIT], mismatches);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/swarq_pkg.sv
rtl/swarq_rtt.sv
rtl/stop_wait_arq_sender_rtt.sv
test/stop_wait_arq_sender_rtt_tb.sv
